/* src/mrt_pkg.sv */
// Package for the mapped region table: shared types, codes and sizes.
// Depends on nothing; mapped_region_table_top imports it.
package mrt_pkg;

   localparam int MaxEntries = 64;
   localparam int IdxBits    = $clog2(MaxEntries);
   localparam int CntBits    = $clog2(MaxEntries + 1);
   localparam int PageBits   = 52;
   localparam int LenBits    = PageBits + 1;
   localparam int EntryBits  = PageBits + LenBits + 4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_UNAUTH   = 3'd2;
   localparam logic [2:0] ST_MAPPED   = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_NOTFOUND = 3'd5;

   localparam logic [1:0] KIND_MAP    = 2'd0;
   localparam logic [1:0] KIND_UNMAP  = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   localparam logic [2:0] CSR_KMODE  = 3'd0;
   localparam logic [2:0] CSR_HSTART = 3'd1;
   localparam logic [2:0] CSR_HEND   = 3'd2;
   localparam logic [2:0] CSR_KSTART = 3'd3;
   localparam logic [2:0] CSR_KEND   = 3'd4;

   typedef struct packed {
      logic [1:0]          kind;
      logic [PageBits-1:0] base_page;
      logic [PageBits-1:0] page_count;
      logic [3:0]          access_flags;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [PageBits-1:0] mapped_pages;
      logic [PageBits-1:0] region_base;
      logic [LenBits-1:0]  region_pages;
      logic [3:0]          region_flags;
   } rsp_type;

   typedef struct packed {
      logic [PageBits-1:0] base;
      logic [LenBits-1:0]  length;
      logic [3:0]          flags;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
      S_FIX, S_DONE
   } state_type;

endpackage

/* src/mrt_ram.sv */
// Generic single-port-write RAM with registered read.
// No package dependencies.
module mrt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* src/mapped_region_table_top.sv */
// Mapped region table top level: sequencer and table RAM.
// Depends on mrt_pkg and mrt_ram.
// A transaction runs a scan that reads the entries in order, then for some requests an
// entry shift and a final entry write, all through the single table RAM port pair. One
// transaction at a time; the next one is accepted in the cycle after the response leaves.
// Reset is synchronous; it clears the control state and entry count and loads the
// register defaults; the RAM is not cleared.
module mapped_region_table_top
   import mrt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [LenBits-1:0]  csr_data
);

   // Configuration registers.
   logic               kmode_ff;
   logic [LenBits-1:0] hstart_ff, hend_ff, kstart_ff, kend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmode_ff  <= 1'b0;
         hstart_ff <= LenBits'(64'd34359738368);
         hend_ff   <= LenBits'(64'd4503565267632128);
         kstart_ff <= LenBits'(64'd4503565267632128);
         kend_ff   <= LenBits'(64'd4503599627370496);
      end else if (csr_write) begin
         case (csr_index)
            CSR_KMODE:  kmode_ff  <= csr_data[0];
            CSR_HSTART: hstart_ff <= csr_data;
            CSR_HEND:   hend_ff   <= csr_data;
            CSR_KSTART: kstart_ff <= csr_data;
            CSR_KEND:   kend_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   rsp_type              rsp_ff, rsp_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic [CntBits-1:0]   ptr_ff, ptr_in;      // scan pointer
   logic [CntBits-1:0]   idx_ff, idx_in;      // insertion point or container
   logic                 found_ff, found_in;  // container or overlap seen
   logic                 prev_ok_ff, prev_ok_in;
   entry_type            prev_ff, prev_in;    // entry just before idx
   entry_type            cur_ff, cur_in;      // entry at idx
   logic                 cur_ok_ff, cur_ok_in;
   logic [2:0]           stat_ff, stat_in;
   logic                 ins_ff, ins_in;      // shift direction: 1 insert, 0 remove
   logic [CntBits-1:0]   sh_ff, sh_in;        // shift pointer
   entry_type            new_ff, new_in;      // entry written at the shift target
   logic [CntBits-1:0]   fix_ff, fix_in;
   entry_type            fixv_ff, fixv_in;
   logic                 fixen_ff, fixen_in;

   logic                 wr_en;
   logic [IdxBits-1:0]   wr_addr, rd_addr;
   entry_type            wr_data, rd_data;

   mrt_ram #(.Width(EntryBits), .Depth(MaxEntries)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request range end, one bit wider than a page number.
   logic [LenBits-1:0] rend, rb;
   logic [LenBits-1:0] e_end;
   assign rb    = {1'b0, req_ff.base_page};
   assign rend  = rb + {1'b0, req_ff.page_count};
   assign e_end = {1'b0, rd_data.base} + rd_data.length;

   function automatic logic ovl(logic [LenBits-1:0] a0, logic [LenBits-1:0] a1,
                                logic [LenBits-1:0] b0, logic [LenBits-1:0] b1);
      return (b1 > b0) && (a0 < b1) && (b0 < a1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      req_ff <= req_in;   rsp_ff <= rsp_in;   ptr_ff <= ptr_in;
      idx_ff <= idx_in;   found_ff <= found_in; prev_ok_ff <= prev_ok_in;
      prev_ff <= prev_in; cur_ff <= cur_in;   cur_ok_ff <= cur_ok_in;
      stat_ff <= stat_in; ins_ff <= ins_in;   sh_ff <= sh_in;
      new_ff <= new_in;   fix_ff <= fix_in;   fixv_ff <= fixv_in;
      fixen_ff <= fixen_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_data  = rsp_ff;

   // A remove shift runs until the pointer reaches the already reduced count.
   logic sh_need, sh_end;
   assign sh_end = ins_ff ? (sh_ff == idx_ff) : (sh_ff >= count_ff);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_CHECK;
         S_CHECK:    state_in = (stat_in != ST_OK) ? S_DONE : S_SCAN_RD;
         S_SCAN_RD:  state_in = (ptr_ff >= count_ff) ? S_DECIDE : S_SCAN;
         S_SCAN:     state_in = S_SCAN_RD;
         S_DECIDE:   state_in = S_DONE;
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_FIX:      state_in = S_DONE;
         S_DONE:     if (!rsp_stall) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
      // Datapath decisions may redirect the flow; see the output block.
      if (state_ff == S_SCAN && found_in && req_ff.kind != KIND_MAP) state_in = S_DECIDE;
      if (state_ff == S_SCAN && found_in && req_ff.kind == KIND_MAP) state_in = S_DONE;
      if (state_ff == S_DECIDE && sh_need) state_in = S_SHIFT_RD;
      if (state_ff == S_DECIDE && !sh_need && fixen_in) state_in = S_FIX;
      if (state_ff == S_SHIFT_RD && sh_end) state_in = fixen_ff ? S_FIX : S_DONE;
   end

   // Datapath and output logic.
   always_comb begin
      logic mp, mn, hole, kern, full;
      logic [LenBits-1:0] ee;
      req_in = req_ff; rsp_in = rsp_ff; count_in = count_ff; ptr_in = ptr_ff;
      idx_in = idx_ff; found_in = found_ff; prev_ok_in = prev_ok_ff;
      prev_in = prev_ff; cur_in = cur_ff; cur_ok_in = cur_ok_ff; stat_in = stat_ff;
      ins_in = ins_ff; sh_in = sh_ff; new_in = new_ff; fix_in = fix_ff;
      fixv_in = fixv_ff; fixen_in = fixen_ff; sh_need = 1'b0;
      wr_en = 1'b0; wr_addr = '0; wr_data = new_ff;
      rd_addr = ptr_ff[IdxBits-1:0];
      mp = 1'b0; mn = 1'b0; full = (count_ff >= CntBits'(MaxEntries)); ee = '0;
      hole = ovl(rb, rend, hstart_ff, hend_ff);
      kern = !kmode_ff && ovl(rb, rend, kstart_ff, kend_ff);
      case (state_ff)
         S_IDLE: begin
            req_in = req_data; ptr_in = '0; idx_in = '0; found_in = 1'b0;
            prev_ok_in = 1'b0; cur_ok_in = 1'b0; fixen_in = 1'b0;
         end
         S_CHECK: begin
            rsp_in = '0;
            rsp_in.status = ST_INVALID;
            stat_in = ST_OK;
            case (req_ff.kind)
               KIND_MAP, KIND_UNMAP: begin
                  if (req_ff.page_count == '0 || rend[LenBits-1] && rend[LenBits-2:0] != '0)
                     stat_in = ST_INVALID;
                  else if (hole) stat_in = ST_INVALID;
                  else if (kern) stat_in = ST_UNAUTH;
               end
               KIND_LOOKUP: if (req_ff.page_count == '0) stat_in = ST_NOTFOUND;
               default: stat_in = ST_INVALID;
            endcase
            rsp_in.status = stat_in;
         end
         S_SCAN_RD: ;
         S_SCAN: begin
            ptr_in = ptr_ff + 1'b1;
            if (req_ff.kind == KIND_MAP) begin
               if (ovl(rb, rend, {1'b0, rd_data.base}, e_end)) begin
                  found_in = 1'b1; rsp_in.status = ST_MAPPED;
               end else if (e_end <= rb) begin
                  idx_in = ptr_ff + 1'b1; prev_ok_in = 1'b1; prev_in = rd_data;
               end else if (!cur_ok_ff) begin
                  cur_ok_in = 1'b1; cur_in = rd_data;
               end
            end else if ({1'b0, rd_data.base} <= rb && rend <= e_end) begin
               found_in = 1'b1; idx_in = ptr_ff; cur_in = rd_data;
            end
         end
         S_DECIDE: begin
            rsp_in.status = ST_OK;
            if (req_ff.kind == KIND_MAP) begin
               mp = prev_ok_ff && ({1'b0, prev_ff.base} + prev_ff.length == rb)
                    && prev_ff.flags == req_ff.access_flags;
               mn = cur_ok_ff && ({1'b0, cur_ff.base} == rend)
                    && cur_ff.flags == req_ff.access_flags;
               fix_in = idx_ff - 1'b1;
               fixv_in = prev_ff;
               if (mp && mn) begin
                  fixv_in.length = prev_ff.length + {1'b0, req_ff.page_count} + cur_ff.length;
                  fixen_in = 1'b1; ins_in = 1'b0; sh_in = idx_ff; sh_need = 1'b1;
                  count_in = count_ff - 1'b1;
               end else if (mp) begin
                  fixv_in.length = prev_ff.length + {1'b0, req_ff.page_count};
                  fixen_in = 1'b1;
               end else if (mn) begin
                  fix_in = idx_ff; fixv_in = cur_ff; fixv_in.base = req_ff.base_page;
                  fixv_in.length = cur_ff.length + {1'b0, req_ff.page_count};
                  fixen_in = 1'b1;
               end else if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  fix_in = idx_ff; fixen_in = 1'b1;
                  fixv_in.base = req_ff.base_page;
                  fixv_in.length = {1'b0, req_ff.page_count};
                  fixv_in.flags = req_ff.access_flags;
                  ins_in = 1'b1; sh_in = count_ff; count_in = count_ff + 1'b1;
                  sh_need = (count_ff != idx_ff);
               end
               if (rsp_in.status == ST_OK) rsp_in.mapped_pages = req_ff.page_count;
            end else if (!found_ff) begin
               rsp_in.status = ST_NOTFOUND;
            end else if (req_ff.kind == KIND_LOOKUP) begin
               rsp_in.region_base = cur_ff.base;
               rsp_in.region_pages = cur_ff.length;
               rsp_in.region_flags = cur_ff.flags;
            end else begin
               ee = {1'b0, cur_ff.base} + cur_ff.length;
               fix_in = idx_ff; fixv_in = cur_ff;
               if ({1'b0, cur_ff.base} == rb && ee == rend) begin
                  ins_in = 1'b0; sh_in = idx_ff; count_in = count_ff - 1'b1;
                  sh_need = (idx_ff + 1'b1 < count_ff);
               end else if ({1'b0, cur_ff.base} == rb) begin
                  fixv_in.base = rend[PageBits-1:0]; fixv_in.length = ee - rend;
                  fixen_in = 1'b1;
               end else if (ee == rend) begin
                  fixv_in.length = cur_ff.length - {1'b0, req_ff.page_count};
                  fixen_in = 1'b1;
               end else if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  // Split: shift the tail up, write the right part, then trim the left.
                  fixv_in.length = rb - {1'b0, cur_ff.base}; fixen_in = 1'b1;
                  new_in.base = rend[PageBits-1:0]; new_in.length = ee - rend;
                  new_in.flags = cur_ff.flags;
                  ins_in = 1'b1; sh_in = count_ff; idx_in = idx_ff + 1'b1;
                  count_in = count_ff + 1'b1; sh_need = 1'b1;
               end
            end
            if (!sh_need && ins_in && fixen_in && req_ff.kind == KIND_MAP && !mp && !mn)
               fix_in = idx_ff;
         end
         S_SHIFT_RD: begin
            // Insert reads sh-1 to move up; remove reads sh+1 to move down.
            rd_addr = ins_ff ? IdxBits'(sh_ff - 1'b1) : IdxBits'(sh_ff + 1'b1);
            if (sh_end && ins_ff && !(req_ff.kind == KIND_MAP)) begin
               wr_en = 1'b1; wr_addr = idx_ff[IdxBits-1:0]; wr_data = new_ff;
            end
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1; wr_addr = sh_ff[IdxBits-1:0]; wr_data = rd_data;
            sh_in = ins_ff ? sh_ff - 1'b1 : sh_ff + 1'b1;
         end
         S_FIX: begin
            wr_en = 1'b1; wr_addr = fix_ff[IdxBits-1:0]; wr_data = fixv_ff;
         end
         default: ;
      endcase
   end

endmodule
